@@ hw/rtl/pgpg_pkg.sv @@
// shared types and constants of the plot grid pixel generator
// used by every rtl file of the block, depends on nothing
`default_nettype none

package pgpg_pkg;

   // pipeline depth, input register through output register
   localparam int NUM_STAGES = 6;

   // payload widths
   localparam int X_W     = 9;
   localparam int Y_W     = 8;
   localparam int COLOR_W = 16;

   // register widths
   localparam int OFFSET_W = 10;
   localparam int PITCH_W  = 12;

   // configuration bus
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // register reset values
   localparam logic [COLOR_W-1:0]  LINE_COLOR_RST = 16'd4228;
   localparam logic [OFFSET_W-1:0] OFFSET_RST     = 10'd0;
   localparam logic [PITCH_W-1:0]  PITCH_RST      = 12'd483;

   // per stage load enables of the datapath stages ahead of the output register
   typedef logic [NUM_STAGES-2:0] stage_en_type;

   // register map, word index
   typedef enum logic [1:0] {
      REG_LINE_COLOR      = 2'd0,
      REG_VERTICAL_OFFSET = 2'd1,
      REG_VERTICAL_PITCH  = 2'd2
   } reg_index_type;

   // grid placement settings seen by the line datapath
   typedef struct packed {
      logic [OFFSET_W-1:0] vertical_offset;
      logic [PITCH_W-1:0]  vertical_pitch;
   } grid_cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/pgpg_lines.sv @@
// straight grid lines: edge columns, frequency grid columns, every 29th row
// pipelined restoring remainder over stages 1 to 4; depends on pgpg_pkg
`default_nettype none

module pgpg_lines #(
   parameter int PLOT_WIDTH = 291
) (
   input  wire                          clock,
   input  wire pgpg_pkg::stage_en_type  stage_en,
   input  wire pgpg_pkg::grid_cfg_type  cfg,
   input  wire  [pgpg_pkg::X_W-1:0]     pixel_x,
   input  wire  [pgpg_pkg::Y_W-1:0]     pixel_y,
   output logic                         line_hit
);

   localparam int SUM_W       = pgpg_pkg::OFFSET_W + 1;
   localparam int DVD_W       = 16;
   localparam int DIV_STAGES  = pgpg_pkg::NUM_STAGES - 2;
   localparam int STEPS       = DVD_W / DIV_STAGES;
   localparam int REM_W       = pgpg_pkg::PITCH_W;
   localparam int PITCH_SCALE = 10;
   localparam int ROW_PITCH   = 29;
   localparam int Y_MAX       = (1 << pgpg_pkg::Y_W) - 1;

   // row on a horizontal line when it is a multiple of the row pitch
   function automatic logic row_line(input logic [pgpg_pkg::Y_W-1:0] y);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= Y_MAX / ROW_PITCH; k++) begin
         if (y == pgpg_pkg::Y_W'(k * ROW_PITCH)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   logic [SUM_W-1:0] sum;
   logic [DVD_W-1:0] dvd_in;
   logic             edge_in;

   logic [DVD_W-1:0] dvd_ff  [DIV_STAGES];
   logic [REM_W-1:0] rem_ff  [DIV_STAGES];
   logic             edge_ff [DIV_STAGES+1];
   logic             row_ff  [DIV_STAGES+1];

   // scaled column position, times ten as two shifts
   assign sum     = SUM_W'(pixel_x) + SUM_W'(cfg.vertical_offset);
   assign dvd_in  = (DVD_W'(sum) << 3) + (DVD_W'(sum) << 1);
   assign edge_in = (pixel_x == '0) ||
                    (pixel_x == pgpg_pkg::X_W'(PLOT_WIDTH - 1));

   // stage 0 register
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dvd_ff[0]  <= dvd_in;
         edge_ff[0] <= edge_in;
         row_ff[0]  <= row_line(pixel_y);
      end
   end

   // remainder stages, four dividend bits each
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [REM_W-1:0] rem_start;
      logic [REM_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_start = '0;
      end else begin : g_next
         assign rem_start = rem_ff[k-1];
      end

      // shift in one bit, subtract pitch when it fits
      always_comb begin
         logic [REM_W:0] trial;
         rem_in = rem_start;
         for (int j = 0; j < STEPS; j++) begin
            trial = {rem_in, dvd_ff[k][DVD_W-1-k*STEPS-j]};
            if (trial >= {1'b0, cfg.vertical_pitch}) begin
               trial = trial - {1'b0, cfg.vertical_pitch};
            end
            rem_in = trial[REM_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k+1]) begin
            rem_ff[k]    <= rem_in;
            edge_ff[k+1] <= edge_ff[k];
            row_ff[k+1]  <= row_ff[k];
         end
      end

      if (k + 1 < DIV_STAGES) begin : g_dvd
         always_ff @(posedge clock) begin
            if (stage_en[k+1]) begin
               dvd_ff[k+1] <= dvd_ff[k];
            end
         end
      end
   end

   // any straight line; a zero pitch leaves only the edge columns and the rows
   assign line_hit = edge_ff[DIV_STAGES] || row_ff[DIV_STAGES] ||
                     ((cfg.vertical_pitch != '0) &&
                      (rem_ff[DIV_STAGES-1] < REM_W'(PITCH_SCALE)));

endmodule

`default_nettype wire

@@ hw/rtl/pgpg_smith.sv @@
// smith chart overlay: outer circle, resistance circles, reactance arcs
// squares, circle boundary tests and priority decision in stages; depends on pgpg_pkg
`default_nettype none

module pgpg_smith (
   input  wire                          clock,
   input  wire pgpg_pkg::stage_en_type  stage_en,
   input  wire  [pgpg_pkg::X_W-1:0]     pixel_x,
   input  wire  [pgpg_pkg::Y_W-1:0]     pixel_y,
   output logic                         smith_hit
);

   localparam int D_W  = 11;
   localparam int SQ_W = 2 * D_W;

   // chart geometry
   localparam int SMITH_CX = 146;
   localparam int SMITH_CY = 116;
   localparam int SMITH_R  = 116;
   localparam int SMITH_UX = SMITH_CX + SMITH_R;
   localparam int R_HALF   = 58;
   localparam int R_QUART  = 29;
   localparam int R_3Q     = 87;
   localparam int R_TWICE  = 232;

   // squared terms
   localparam int SQ_XC    = 0;
   localparam int SQ_U     = 1;
   localparam int SQ_U29   = 2;
   localparam int SQ_U58   = 3;
   localparam int SQ_U87   = 4;
   localparam int SQ_V     = 5;
   localparam int SQ_VP58  = 6;
   localparam int SQ_VM58  = 7;
   localparam int SQ_VP116 = 8;
   localparam int SQ_VM116 = 9;
   localparam int SQ_VP232 = 10;
   localparam int SQ_VM232 = 11;
   localparam int NUM_SQ   = 12;

   // circles, each a pair of squared terms and a radius
   localparam int C_OUTER   = 0;
   localparam int C_P58     = 1;
   localparam int C_M58     = 2;
   localparam int C_29      = 3;
   localparam int C_P116    = 4;
   localparam int C_M116    = 5;
   localparam int C_58      = 6;
   localparam int C_P232    = 7;
   localparam int C_M232    = 8;
   localparam int C_87      = 9;
   localparam int NUM_CIRC  = 10;

   localparam int CIRC_A [NUM_CIRC] = '{SQ_XC, SQ_U, SQ_U, SQ_U29, SQ_U, SQ_U,
                                        SQ_U58, SQ_U, SQ_U, SQ_U87};
   localparam int CIRC_B [NUM_CIRC] = '{SQ_V, SQ_VP58, SQ_VM58, SQ_V, SQ_VP116,
                                        SQ_VM116, SQ_V, SQ_VP232, SQ_VM232, SQ_V};
   localparam int CIRC_R [NUM_CIRC] = '{SMITH_R, R_HALF, R_HALF, R_QUART, SMITH_R,
                                        SMITH_R, R_HALF, R_TWICE, R_TWICE, R_3Q};

   typedef enum logic [1:0] {
      SIDE_IN  = 2'd0,
      SIDE_ON  = 2'd1,
      SIDE_OUT = 2'd2
   } side_type;

   // integer boundary rule: inside at or below -r, outside above r, else on
   function automatic side_type circle_side(input logic signed [SQ_W-1:0] sa,
                                            input logic signed [SQ_W-1:0] sb,
                                            input int r);
      logic signed [SQ_W-1:0] rs;
      logic signed [SQ_W-1:0] d;
      side_type side;
      rs = SQ_W'(r);
      d  = sa + sb - rs * rs;
      if (d <= -rs) begin
         side = SIDE_IN;
      end else if (d > rs) begin
         side = SIDE_OUT;
      end else begin
         side = SIDE_ON;
      end
      return side;
   endfunction

   logic [pgpg_pkg::X_W-1:0] x_ff;
   logic [pgpg_pkg::Y_W-1:0] y_ff;
   logic signed [D_W-1:0]    xs;
   logic signed [D_W-1:0]    ys;
   logic signed [D_W-1:0]    u;
   logic signed [D_W-1:0]    v;
   logic signed [D_W-1:0]    diff   [NUM_SQ];
   logic signed [SQ_W-1:0]   sq_ff  [NUM_SQ];
   side_type                 side_in [NUM_CIRC];
   side_type                 side_ff [NUM_CIRC];
   logic                     hit_in;
   logic                     hit_ff [2];

   // stage 0: coordinate register
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff <= pixel_x;
         y_ff <= pixel_y;
      end
   end

   // offsets from the chart centers
   assign xs = signed'(D_W'(x_ff));
   assign ys = signed'(D_W'(y_ff));
   assign u  = xs - D_W'(SMITH_UX);
   assign v  = ys - D_W'(SMITH_CY);

   assign diff[SQ_XC]    = xs - D_W'(SMITH_CX);
   assign diff[SQ_U]     = u;
   assign diff[SQ_U29]   = u + D_W'(R_QUART);
   assign diff[SQ_U58]   = u + D_W'(R_HALF);
   assign diff[SQ_U87]   = u + D_W'(R_3Q);
   assign diff[SQ_V]     = v;
   assign diff[SQ_VP58]  = v + D_W'(R_HALF);
   assign diff[SQ_VM58]  = v - D_W'(R_HALF);
   assign diff[SQ_VP116] = v + D_W'(SMITH_R);
   assign diff[SQ_VM116] = v - D_W'(SMITH_R);
   assign diff[SQ_VP232] = v + D_W'(R_TWICE);
   assign diff[SQ_VM232] = v - D_W'(R_TWICE);

   // stage 1: squares
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < NUM_SQ; i++) begin
            sq_ff[i] <= diff[i] * diff[i];
         end
      end
   end

   // boundary test of every circle
   always_comb begin
      for (int c = 0; c < NUM_CIRC; c++) begin
         side_in[c] = circle_side(sq_ff[CIRC_A[c]], sq_ff[CIRC_B[c]], CIRC_R[c]);
      end
   end

   // stage 2: circle sides
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int c = 0; c < NUM_CIRC; c++) begin
            side_ff[c] <= side_in[c];
         end
      end
   end

   // chart priority: inner circles mask the arcs drawn after them
   always_comb begin
      if (side_ff[C_OUTER] == SIDE_OUT) begin
         hit_in = 1'b0;
      end else if (side_ff[C_OUTER] == SIDE_ON) begin
         hit_in = 1'b1;
      end else if (side_ff[C_P58] == SIDE_ON || side_ff[C_M58] == SIDE_ON) begin
         hit_in = 1'b1;
      end else if (side_ff[C_29] == SIDE_IN) begin
         hit_in = 1'b0;
      end else if (side_ff[C_29] == SIDE_ON) begin
         hit_in = 1'b1;
      end else if (side_ff[C_P116] == SIDE_ON || side_ff[C_M116] == SIDE_ON) begin
         hit_in = 1'b1;
      end else if (side_ff[C_58] == SIDE_IN) begin
         hit_in = 1'b0;
      end else if (side_ff[C_58] == SIDE_ON) begin
         hit_in = 1'b1;
      end else begin
         hit_in = (side_ff[C_P232] == SIDE_ON) || (side_ff[C_M232] == SIDE_ON) ||
                  (side_ff[C_87] == SIDE_ON);
      end
   end

   // stages 3 and 4: decision, then delay to line up with the line datapath
   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         hit_ff[0] <= hit_in;
      end
      if (stage_en[4]) begin
         hit_ff[1] <= hit_ff[0];
      end
   end

   assign smith_hit = hit_ff[1];

endmodule

`default_nettype wire

@@ hw/rtl/plot_grid_pixel_generator_unit.sv @@
// top level of the plot grid pixel generator: handshake pipeline, registers
// depends on pgpg_pkg, pgpg_lines and pgpg_smith
//
// usage
//   req channel: one pixel coordinate (req_pixel_x, req_pixel_y) per
//   transaction, valid/ready handshake
//   rsp channel: one rsp_pixel_color per transaction, in order: the line
//   color when the pixel lies on a grid line or on the smith chart, else zero
//   register port: apb style, line_color at 0x0, vertical_offset at 0x4,
//   vertical_pitch at 0x8; pready is always high, write only while idle
// timing
//   six register stages; an accepted transaction moves through stages 0 to 5
//   in order and is shown on rsp from the output register
//   one transaction per cycle sustained while rsp_ready stays high; the depth
//   is set by the four stage remainder unit of the frequency grid columns
// stall
//   every stage holds its transaction while the next one is full and
//   stalled; empty stages keep filling, so req_ready drops only when all
//   six stages hold a transaction and rsp_ready is low
// reset
//   clears all stage valid bits and loads the register reset values
//   (line color 0x1084, offset 0, pitch 483)
`default_nettype none

module plot_grid_pixel_generator_unit #(
   parameter int PLOT_WIDTH = 291
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [pgpg_pkg::X_W-1:0]         req_pixel_x,
   input  wire  [pgpg_pkg::Y_W-1:0]         req_pixel_y,

   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [pgpg_pkg::COLOR_W-1:0]     rsp_pixel_color,

   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [pgpg_pkg::ADDR_W-1:0]      paddr,
   input  wire  [pgpg_pkg::DATA_W-1:0]      pwdata,
   output logic [pgpg_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);

   localparam int NS = pgpg_pkg::NUM_STAGES;

   logic [pgpg_pkg::COLOR_W-1:0]  line_color_ff;
   logic [pgpg_pkg::COLOR_W-1:0]  line_color_in;
   logic [pgpg_pkg::OFFSET_W-1:0] offset_ff;
   logic [pgpg_pkg::OFFSET_W-1:0] offset_in;
   logic [pgpg_pkg::PITCH_W-1:0]  pitch_ff;
   logic [pgpg_pkg::PITCH_W-1:0]  pitch_in;
   logic                          csr_write;
   logic [1:0]                    reg_index;

   logic [NS-1:0]                 valid_ff;
   logic [NS-1:0]                 valid_in;
   logic [NS-1:0]                 stage_en;
   logic [pgpg_pkg::COLOR_W-1:0]  color_ff;
   logic [pgpg_pkg::COLOR_W-1:0]  color_in;
   logic                          line_hit;
   logic                          smith_hit;
   pgpg_pkg::grid_cfg_type        grid_cfg;

   // register write decode
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      line_color_in = line_color_ff;
      offset_in     = offset_ff;
      pitch_in      = pitch_ff;
      if (csr_write) begin
         unique case (reg_index)
            pgpg_pkg::REG_LINE_COLOR:      line_color_in = pwdata[pgpg_pkg::COLOR_W-1:0];
            pgpg_pkg::REG_VERTICAL_OFFSET: offset_in     = pwdata[pgpg_pkg::OFFSET_W-1:0];
            pgpg_pkg::REG_VERTICAL_PITCH:  pitch_in      = pwdata[pgpg_pkg::PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_color_ff <= pgpg_pkg::LINE_COLOR_RST;
         offset_ff     <= pgpg_pkg::OFFSET_RST;
         pitch_ff      <= pgpg_pkg::PITCH_RST;
      end else begin
         line_color_ff <= line_color_in;
         offset_ff     <= offset_in;
         pitch_ff      <= pitch_in;
      end
   end

   // register read mux
   always_comb begin
      unique case (reg_index)
         pgpg_pkg::REG_LINE_COLOR:      prdata = pgpg_pkg::DATA_W'(line_color_ff);
         pgpg_pkg::REG_VERTICAL_OFFSET: prdata = pgpg_pkg::DATA_W'(offset_ff);
         pgpg_pkg::REG_VERTICAL_PITCH:  prdata = pgpg_pkg::DATA_W'(pitch_ff);
         default:                       prdata = '0;
      endcase
   end

   assign grid_cfg.vertical_offset = offset_ff;
   assign grid_cfg.vertical_pitch  = pitch_ff;

   // stage load enables, a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[0];

   // valid bits travel with the data
   always_comb begin
      valid_in[0] = req_valid;
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // straight line datapath
   pgpg_lines #(
      .PLOT_WIDTH (PLOT_WIDTH)
   ) u_lines (
      .clock    (clock),
      .stage_en (stage_en[NS-2:0]),
      .cfg      (grid_cfg),
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .line_hit (line_hit)
   );

   // smith chart datapath
   pgpg_smith u_smith (
      .clock     (clock),
      .stage_en  (stage_en[NS-2:0]),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .smith_hit (smith_hit)
   );

   // output register
   assign color_in = (line_hit || smith_hit) ? line_color_ff : '0;

   always_ff @(posedge clock) begin
      if (stage_en[NS-1]) begin
         color_ff <= color_in;
      end
   end

   assign rsp_valid       = valid_ff[NS-1];
   assign rsp_pixel_color = color_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pgpg_checker.sv @@
// port level checks of the plot grid pixel generator, bound to the top level
// depends on pgpg_pkg and plot_grid_pixel_generator_unit
`default_nettype none

module pgpg_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [pgpg_pkg::COLOR_W-1:0]  rsp_pixel_color
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a receiver that takes results never blocks the input
   a_no_backpressure: assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color))
      else $error("stalled result changed or dropped");

   // an accepted request shows its result on rsp once it has passed the pipeline,
   // with the receiver ready throughout
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && req_ready, 6) && !$past(reset, 6) &&
       !$past(reset, 5) && !$past(reset, 4) && !$past(reset, 3) &&
       !$past(reset, 2) && !$past(reset, 1) &&
       $past(rsp_ready, 5) && $past(rsp_ready, 4) && $past(rsp_ready, 3) &&
       $past(rsp_ready, 2) && $past(rsp_ready, 1)) |-> rsp_valid)
      else $error("result missing at the sixth edge after acceptance");

endmodule

bind plot_grid_pixel_generator_unit pgpg_checker u_pgpg_checker (.*);

`default_nettype wire
